// ----- hdl/kvi_pkg.sv -----
package kvi_pkg;

  localparam int MAX_KEYS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int KEY_COUNT_W = 7;
  localparam int KEY_INDEX_W = 6;
  localparam int DATA_W      = 32;
  localparam int AXES        = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic CFG_KEY_COUNT   = 1'b0;
  localparam logic CFG_EMPTY_VALUE = 1'b1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] tm;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SCAN,
    ST_LOAD0,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    ADDR_FIRST,
    ADDR_LAST,
    ADDR_NEXT,
    ADDR_PREV
  } addr_sel_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_EMPTY,
    RES_KEY
  } res_op_e;

  typedef struct packed {
    logic      key_write;
    logic      query_start;
    addr_sel_e addr_sel;
    logic      idx_inc;
    logic      key1_cap;
    logic      key0_cap;
    logic      div_step;
    logic      mul_step;
    logic      acc_step;
    res_op_e   res_op;
    logic      out_load;
  } ctrl_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic q_le_t;
    logic q_ge_t;
    logic q_lt_t;
    logic div_last;
    logic ax_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/kvi_ctrl.sv -----
module kvi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            cmd_i,
  input  kvi_pkg::stat_t  stat_i,
  output kvi_pkg::ctrl_t  ctrl_o
);
  import kvi_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.addr_sel = ADDR_FIRST;
    ctrl_o.res_op   = RES_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_WRITE) begin
          ctrl_o.key_write = 1'b1;
        end else if (accept) begin
          ctrl_o.query_start = 1'b1;
          if (stat_i.n_zero) begin
            ctrl_o.res_op = RES_EMPTY;
            state_d = ST_OUT;
          end else begin
            state_d = ST_CHK_FIRST;
          end
        end
      end
      ST_CHK_FIRST: begin
        if (stat_i.n_one || stat_i.q_le_t) begin
          ctrl_o.res_op = RES_KEY;
          state_d = ST_OUT;
        end else begin
          ctrl_o.addr_sel = ADDR_LAST;
          state_d = ST_CHK_LAST;
        end
      end
      ST_CHK_LAST: begin
        if (stat_i.q_ge_t) begin
          ctrl_o.res_op = RES_KEY;
          state_d = ST_OUT;
        end else begin
          ctrl_o.addr_sel = ADDR_NEXT;
          ctrl_o.idx_inc  = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // segment end found: fetch its start key
        if (stat_i.q_lt_t) begin
          ctrl_o.key1_cap = 1'b1;
          ctrl_o.addr_sel = ADDR_PREV;
          state_d = ST_LOAD0;
        end else begin
          ctrl_o.addr_sel = ADDR_NEXT;
          ctrl_o.idx_inc  = 1'b1;
        end
      end
      ST_LOAD0: begin
        ctrl_o.key0_cap = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl_o.mul_step = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        ctrl_o.acc_step = 1'b1;
        state_d = stat_i.ax_last ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/kvi_datapath.sv -----
module kvi_datapath #(
  parameter int MAX_KEYS  = kvi_pkg::MAX_KEYS_DEF,
  parameter int FRAC_BITS = kvi_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_index_i,
  input  logic [kvi_pkg::DATA_W-1:0]             cfg_wdata_i,
  input  logic [kvi_pkg::KEY_INDEX_W-1:0]        key_index_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      key_time_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      key_x_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      key_y_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      key_z_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      query_time_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [kvi_pkg::DATA_W-1:0]      out_x_o,
  output logic signed [kvi_pkg::DATA_W-1:0]      out_y_o,
  output logic signed [kvi_pkg::DATA_W-1:0]      out_z_o,
  input  kvi_pkg::ctrl_t                         ctrl_i,
  output kvi_pkg::stat_t                         stat_o
);
  import kvi_pkg::*;

  localparam int AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNTW = $clog2(MAX_KEYS + 1);
  localparam int DCW  = $clog2(FRAC_BITS);
  localparam int PW   = 34 + FRAC_BITS;
  localparam int SW   = PW + 1;

  // configuration
  logic [KEY_COUNT_W-1:0]   key_count_q;
  logic signed [DATA_W-1:0] empty_q;

  // key memory
  key_t                     mem_q [MAX_KEYS];
  key_t                     rd_key_q;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic                     wr_ok;

  logic [CNTW-1:0]          n_cnt;
  logic [AW-1:0]            idx_q;
  logic signed [DATA_W-1:0] q_q;
  logic signed [DATA_W-1:0] t1_q;
  logic signed [DATA_W-1:0] k0_q [AXES];
  logic signed [DATA_W-1:0] k1_q [AXES];

  // restoring divider
  logic [DATA_W-1:0]        rem_q, den_q;
  logic [FRAC_BITS-1:0]     quo_q;
  logic [DCW-1:0]           div_cnt_q;
  logic [DATA_W:0]          rem_sh;
  logic                     rem_ge;
  logic signed [DATA_W:0]   num_w, den_w;

  // lerp
  logic [1:0]               ax_q;
  logic signed [DATA_W:0]   diff_s;
  logic signed [PW-1:0]     prod_q;
  logic signed [SW-1:0]     sum_s;
  logic signed [DATA_W-1:0] sat_s;
  logic signed [DATA_W-1:0] res_q [AXES];

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_x_q, out_y_q, out_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      empty_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_COUNT:   key_count_q <= cfg_wdata_i[KEY_COUNT_W-1:0];
        CFG_EMPTY_VALUE: empty_q     <= cfg_wdata_i;
        default:         key_count_q <= key_count_q;
      endcase
    end
  end

  assign n_cnt = (32'(key_count_q) > 32'(MAX_KEYS)) ? CNTW'(MAX_KEYS) : CNTW'(key_count_q);

  assign wr_addr = AW'(key_index_i);
  assign wr_ok   = (32'(key_index_i) < 32'(MAX_KEYS));

  always_comb begin
    unique case (ctrl_i.addr_sel)
      ADDR_FIRST: rd_addr = '0;
      ADDR_LAST:  rd_addr = AW'(n_cnt - CNTW'(1));
      ADDR_NEXT:  rd_addr = idx_q + AW'(1);
      ADDR_PREV:  rd_addr = idx_q - AW'(1);
      default:    rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_write && wr_ok) begin
      mem_q[wr_addr] <= '{tm: key_time_i, x: key_x_i, y: key_y_i, z: key_z_i};
    end
    rd_key_q <= mem_q[rd_addr];
  end

  assign num_w  = 33'(q_q) - 33'(rd_key_q.tm);
  assign den_w  = 33'(t1_q) - 33'(rd_key_q.tm);
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  assign diff_s = 33'(k1_q[ax_q]) - 33'(k0_q[ax_q]);
  assign sum_s  = SW'(k0_q[ax_q]) + SW'(prod_q >>> FRAC_BITS);

  always_comb begin
    if (sum_s > SW'(SAT_MAX)) begin
      sat_s = SAT_MAX;
    end else if (sum_s < SW'(SAT_MIN)) begin
      sat_s = SAT_MIN;
    end else begin
      sat_s = sum_s[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      div_cnt_q <= '0;
      ax_q      <= '0;
    end else begin
      if (ctrl_i.query_start) begin
        idx_q <= '0;
      end else if (ctrl_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (ctrl_i.key0_cap) begin
        div_cnt_q <= '0;
        ax_q      <= '0;
      end else begin
        if (ctrl_i.div_step) begin
          div_cnt_q <= div_cnt_q + DCW'(1);
        end
        if (ctrl_i.acc_step) begin
          ax_q <= ax_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.query_start) begin
      q_q <= query_time_i;
    end
    if (ctrl_i.key1_cap) begin
      t1_q    <= rd_key_q.tm;
      k1_q[0] <= rd_key_q.x;
      k1_q[1] <= rd_key_q.y;
      k1_q[2] <= rd_key_q.z;
    end
    if (ctrl_i.key0_cap) begin
      k0_q[0] <= rd_key_q.x;
      k0_q[1] <= rd_key_q.y;
      k0_q[2] <= rd_key_q.z;
      rem_q   <= num_w[DATA_W-1:0];
      den_q   <= den_w[DATA_W-1:0];
      quo_q   <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= rem_ge ? DATA_W'(rem_sh - {1'b0, den_q}) : rem_sh[DATA_W-1:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
    end
    if (ctrl_i.mul_step) begin
      prod_q <= PW'(diff_s) * PW'($signed({1'b0, quo_q}));
    end
    unique case (ctrl_i.res_op)
      RES_EMPTY: begin
        res_q[0] <= empty_q;
        res_q[1] <= empty_q;
        res_q[2] <= empty_q;
      end
      RES_KEY: begin
        res_q[0] <= rd_key_q.x;
        res_q[1] <= rd_key_q.y;
        res_q[2] <= rd_key_q.z;
      end
      default: begin
        if (ctrl_i.acc_step) begin
          res_q[ax_q] <= sat_s;
        end
      end
    endcase
    if (ctrl_i.out_load) begin
      out_x_q <= res_q[0];
      out_y_q <= res_q[1];
      out_z_q <= res_q[2];
    end
  end

  // output word register, frees the core while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

  assign stat_o.n_zero   = (n_cnt == '0);
  assign stat_o.n_one    = (n_cnt == CNTW'(1));
  assign stat_o.q_le_t   = (q_q <= rd_key_q.tm);
  assign stat_o.q_ge_t   = (q_q >= rd_key_q.tm);
  assign stat_o.q_lt_t   = (q_q < rd_key_q.tm);
  assign stat_o.div_last = (div_cnt_q == DCW'(FRAC_BITS - 1));
  assign stat_o.ax_last  = (ax_q == 2'(AXES - 1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// ----- hdl/keyframe_vec3_interpolation_unit.sv -----
// keyframe write: the next word is taken straight after
// query: an empty track gives the empty value; a single key, or a query at or beyond
// an end key, gives that key; otherwise a linear scan over keys, the divider (one bit
// a cycle), then a multiply and saturating add per axis, all into the output register
// one query at a time; the output register lets the next word in while a result waits
// reset clears the control state and both config registers; the key memory is not cleared
module keyframe_vec3_interpolation_unit #(
  parameter int MAX_KEYS  = kvi_pkg::MAX_KEYS_DEF,
  parameter int FRAC_BITS = kvi_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_index_i,
  input  logic [kvi_pkg::DATA_W-1:0]             cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   cmd_i,
  input  logic [kvi_pkg::KEY_INDEX_W-1:0]        key_index_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      key_time_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      key_x_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      key_y_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      key_z_i,
  input  logic signed [kvi_pkg::DATA_W-1:0]      query_time_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [kvi_pkg::DATA_W-1:0]      out_x_o,
  output logic signed [kvi_pkg::DATA_W-1:0]      out_y_o,
  output logic signed [kvi_pkg::DATA_W-1:0]      out_z_o
);
  import kvi_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  kvi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  kvi_datapath #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .key_index_i  (key_index_i),
    .key_time_i   (key_time_i),
    .key_x_i      (key_x_i),
    .key_y_i      (key_y_i),
    .key_z_i      (key_z_i),
    .query_time_i (query_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .ctrl_i       (ctrl),
    .stat_o       (stat)
  );

endmodule

// ----- hdl/kvi_checker.sv -----
module kvi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic cmd_i,
  input logic out_valid_o,
  input logic out_stall_i
);
  import kvi_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a keyframe write completes in its own cycle
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_WRITE |=> !in_stall_o)
    else $error("input stalled after a keyframe write");

  // a query occupies the core
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_QUERY |=> in_stall_o)
    else $error("input not stalled after a query");

  // a new result only comes out of a query in progress
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no query in progress");

endmodule

bind keyframe_vec3_interpolation_unit kvi_checker u_kvi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// ----- test/tb_keyframe_vec3_interpolation_unit.sv -----
`timescale 1ns / 100ps

module tb_keyframe_vec3_interpolation_unit;
  import kvi_pkg::*;

  localparam int     SETTLE_CYCLES  = 100;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     ITEM_TARGET    = 1800;
  localparam longint W_HI           = 64'sd2147483647;
  localparam longint W_LO           = -64'sd2147483648;

  // x in the top word, z in the bottom one
  typedef logic [2:0][DATA_W-1:0] vec3_t;

  typedef struct packed {
    logic                     cmd;
    logic [KEY_INDEX_W-1:0]   slot;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] q;
  } word_t;

  typedef enum logic [1:0] {
    ROW_COUNT,
    ROW_EMPTY,
    ROW_KEY,
    ROW_QUERY
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic                   chk;
    logic [KEY_INDEX_W-1:0] slot;
    logic [DATA_W-1:0]      t;
    vec3_t                  v;
  } row_t;

  localparam vec3_t KEY_A = {SAT_MAX, SAT_MIN, 32'hffff_ffff};
  localparam vec3_t KEY_B = {SAT_MIN, SAT_MAX, 32'h0001_2345};

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      cfg_we_i     = 1'b0;
  logic                      cfg_index_i  = 1'b0;
  logic [DATA_W-1:0]         cfg_wdata_i  = '0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_stall_o;
  logic                      cmd_i        = 1'b0;
  logic [KEY_INDEX_W-1:0]    key_index_i  = '0;
  logic signed [DATA_W-1:0]  key_time_i   = '0;
  logic signed [DATA_W-1:0]  key_x_i      = '0;
  logic signed [DATA_W-1:0]  key_y_i      = '0;
  logic signed [DATA_W-1:0]  key_z_i      = '0;
  logic signed [DATA_W-1:0]  query_time_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i  = 1'b0;
  logic signed [DATA_W-1:0]  out_x_o;
  logic signed [DATA_W-1:0]  out_y_o;
  logic signed [DATA_W-1:0]  out_z_o;

  // shadow of the track and registers, updated as words are accepted
  logic signed [DATA_W-1:0]  trk_time [MAX_KEYS_DEF];
  vec3_t                     trk_val  [MAX_KEYS_DEF];
  logic [KEY_COUNT_W-1:0]    track_len = '0;
  logic [DATA_W-1:0]         empty_val = '0;

  vec3_t expected_vecs [$];
  row_t  plan [$];
  int    words_done   = 0;
  int    mismatches   = 0;
  int    quiet_cycles = 0;
  logic  calm;

  // neither random input gaps nor output stalls are inserted over this window
  assign calm = (words_done >= 700) && (words_done < 1000);

  keyframe_vec3_interpolation_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .key_index_i  (key_index_i),
    .key_time_i   (key_time_i),
    .key_x_i      (key_x_i),
    .key_y_i      (key_y_i),
    .key_z_i      (key_z_i),
    .query_time_i (query_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic vec3_t sample_track(input logic signed [DATA_W-1:0] q);
    int     n;
    int     seg;
    int     i;
    int     a;
    longint t0;
    longint t1;
    longint frac;
    longint av;
    longint bv;
    longint res;
    vec3_t  r;
    n = (track_len > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(track_len);
    if (n == 0) return {3{empty_val}};
    seg = -1;
    if (n == 1 || q <= trk_time[0]) seg = 0;
    else if (q >= trk_time[n-1]) seg = n - 1;
    if (seg >= 0) return trk_val[seg];
    for (i = 0; i + 1 < n; i++) begin
      if (seg < 0 && q < trk_time[i+1]) seg = i;
    end
    if (seg < 0) seg = 0;
    t0 = trk_time[seg];
    t1 = trk_time[seg+1];
    frac = 0;
    if (q > t0 && t1 > t0) frac = ((longint'(q) - t0) <<< FRAC_BITS_DEF) / (t1 - t0);
    for (a = 0; a < 3; a++) begin
      av = $signed(trk_val[seg][a]);
      bv = $signed(trk_val[seg+1][a]);
      // arithmetic shift gives the floor for negative products
      res = av + (((bv - av) * frac) >>> FRAC_BITS_DEF);
      if (res > W_HI) res = W_HI;
      else if (res < W_LO) res = W_LO;
      r[a] = res[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] any_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SAT_MIN;
    if (r == 1) return SAT_MAX;
    if (r == 2) return $urandom_range(0, 511) - 256;
    return $urandom();
  endfunction

  function automatic vec3_t rand_vec();
    return {any_word(), any_word(), any_word()};
  endfunction

  function automatic word_t key_word(input logic [KEY_INDEX_W-1:0] slot,
                                     input logic [DATA_W-1:0] t, input vec3_t v);
    word_t w;
    w.cmd = CMD_WRITE;
    w.slot = slot;
    w.t = t;
    {w.x, w.y, w.z} = v;
    w.q = $urandom();
    return w;
  endfunction

  function automatic word_t query_word(input logic [DATA_W-1:0] q);
    word_t w;
    w.cmd = CMD_QUERY;
    w.slot = KEY_INDEX_W'($urandom());
    w.t = $urandom();
    w.x = $urandom();
    w.y = $urandom();
    w.z = $urandom();
    w.q = q;
    return w;
  endfunction

  task automatic add_row(input row_kind_e kind, input logic chk,
                         input logic [KEY_INDEX_W-1:0] slot, input logic [DATA_W-1:0] t,
                         input vec3_t v);
    row_t row;
    row.kind = kind;
    row.chk = chk;
    row.slot = slot;
    row.t = t;
    row.v = v;
    plan.push_back(row);
  endtask

  task automatic report_bad(input string msg);
    mismatches++;
    if (mismatches <= 200) $display("%0t mismatch: %s", $time, msg);
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic push_word(input word_t w, input logic typed, input vec3_t want);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    {cmd_i, key_index_i, key_time_i, key_x_i, key_y_i, key_z_i, query_time_i} = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (w.cmd == CMD_QUERY) begin
      expected_vecs.push_back(typed ? want : sample_track(w.q));
    end else begin
      trk_time[w.slot] = w.t;
      trk_val[w.slot] = {w.x, w.y, w.z};
    end
    words_done++;
    @(negedge clk_i);
  endtask

  // a write word gives no result, so allow the longest query time before reprogramming
  task automatic drain_block();
    in_valid_i = 1'b0;
    while (expected_vecs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    if (idx == CFG_KEY_COUNT) track_len = data[KEY_COUNT_W-1:0];
    else empty_val = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i = !calm && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk_i) begin : check_results
    vec3_t want;
    vec3_t got;
    string axes;
    int    a;
    axes = "zyx";
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_vecs.size() == 0) begin
        report_bad("result with no query outstanding");
      end else begin
        want = expected_vecs.pop_front();
        got = {out_x_o, out_y_o, out_z_o};
        for (a = 2; a >= 0; a--) begin
          if (got[a] !== want[a]) begin
            report_bad($sformatf("out_%c got %h want %h", axes[a], got[a], want[a]));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_keyframe_vec3_interpolation_unit NOT OK");
      $finish;
    end
  end

  initial begin
    int                       n;
    int                       m;
    int                       mode;
    int                       sc;
    int                       nq;
    int                       i;
    int                       k;
    int                       r;
    int                       phase;
    longint                   cur;
    longint                   lo;
    longint                   span;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] q;
    logic [KEY_INDEX_W-1:0]   slot;

    // empty track straight out of reset, then the empty value at both extremes
    add_row(ROW_QUERY, 1'b1, '0, 32'h0, '0);
    add_row(ROW_EMPTY, 1'b0, '0, SAT_MAX, '0);
    add_row(ROW_QUERY, 1'b1, '0, SAT_MIN, {3{SAT_MAX}});
    add_row(ROW_EMPTY, 1'b0, '0, SAT_MIN, '0);
    add_row(ROW_QUERY, 1'b1, '0, SAT_MAX, {3{SAT_MIN}});
    add_row(ROW_KEY, 1'b0, 6'd0, 32'h0001_0000, KEY_A);
    add_row(ROW_KEY, 1'b0, 6'd63, SAT_MAX, {32'h0f0f_0f0f, 32'h5555_aaaa, 32'hfedc_ba98});
    // single key answers every time
    add_row(ROW_COUNT, 1'b0, '0, 32'd1, '0);
    add_row(ROW_QUERY, 1'b1, '0, SAT_MIN, KEY_A);
    add_row(ROW_QUERY, 1'b1, '0, SAT_MAX, KEY_A);
    add_row(ROW_KEY, 1'b0, 6'd1, 32'h0003_0000, KEY_B);
    // upper bits of the count word are junk
    add_row(ROW_COUNT, 1'b0, '0, 32'hffff_ff02, '0);
    add_row(ROW_QUERY, 1'b1, '0, 32'h0001_0000, KEY_A);
    add_row(ROW_QUERY, 1'b1, '0, 32'h0003_0000, KEY_B);
    add_row(ROW_QUERY, 1'b1, '0, SAT_MAX, KEY_B);
    add_row(ROW_QUERY, 1'b0, '0, 32'h0002_0000, '0);
    add_row(ROW_QUERY, 1'b0, '0, 32'h0001_0001, '0);
    add_row(ROW_QUERY, 1'b0, '0, 32'h0002_ffff, '0);
    // segments spanning half the time range
    add_row(ROW_KEY, 1'b0, 6'd2, SAT_MAX, {32'd1, 32'hffff_ffff, SAT_MAX});
    add_row(ROW_KEY, 1'b0, 6'd0, SAT_MIN, KEY_A);
    add_row(ROW_COUNT, 1'b0, '0, 32'd3, '0);
    add_row(ROW_QUERY, 1'b0, '0, 32'h0, '0);
    add_row(ROW_QUERY, 1'b0, '0, 32'h7fff_fffe, '0);
    add_row(ROW_QUERY, 1'b0, '0, 32'h8000_0001, '0);
    // last key earlier than the middle one
    add_row(ROW_KEY, 1'b0, 6'd2, 32'hffff_fffb, {32'd1, 32'hffff_ffff, SAT_MAX});
    add_row(ROW_QUERY, 1'b0, '0, 32'h0002_0000, '0);
    add_row(ROW_QUERY, 1'b0, '0, 32'hffff_ff9c, '0);
    // two keys at the same time
    add_row(ROW_KEY, 1'b0, 6'd1, SAT_MIN, KEY_B);
    add_row(ROW_QUERY, 1'b0, '0, 32'hc000_0000, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[j]) begin
      case (plan[j].kind)
        ROW_COUNT: begin
          drain_block();
          write_reg(CFG_KEY_COUNT, plan[j].t);
        end
        ROW_EMPTY: begin
          drain_block();
          write_reg(CFG_EMPTY_VALUE, plan[j].t);
        end
        ROW_KEY: push_word(key_word(plan[j].slot, plan[j].t, plan[j].v), 1'b0, '0);
        default: push_word(query_word(plan[j].t), plan[j].chk, plan[j].v);
      endcase
    end

    phase = 0;
    while (words_done < ITEM_TARGET) begin
      case (phase)
        0: n = MAX_KEYS_DEF;
        1: n = 127;
        2: n = 0;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 5) n = 0;
          else if (r < 10) n = 1;
          else if (r < 55) n = $urandom_range(2, 8);
          else if (r < 80) n = $urandom_range(9, 63);
          else if (r < 90) n = MAX_KEYS_DEF;
          else if (r < 95) n = 127;
          else n = $urandom_range(65, 126);
        end
      endcase
      m = (n > MAX_KEYS_DEF) ? MAX_KEYS_DEF : n;
      drain_block();
      write_reg(CFG_KEY_COUNT, {25'($urandom()), 7'(n)});
      write_reg(CFG_EMPTY_VALUE, any_word());

      // fresh track: mostly ascending times, sometimes the full range or unsorted
      mode = $urandom_range(0, 9);
      sc = $urandom_range(0, 26);
      cur = longint'($signed($urandom())) >>> $urandom_range(0, 8);
      for (i = 0; i < m; i++) begin
        if (mode == 0) begin
          t = any_word();
        end else if (mode == 1 && m > 1) begin
          t = 32'(W_LO + (longint'(i) * 64'sd4294967295) / longint'(m - 1));
        end else begin
          t = 32'((cur > W_HI) ? W_HI : cur);
          cur += $urandom_range(0, 1 << sc);
        end
        push_word(key_word(6'(i), t, rand_vec()), 1'b0, '0);
      end

      nq = $urandom_range(15, 40);
      for (k = 0; k < nq; k++) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          // stray writes: beyond the track, or over a live key with random time
          if (m < MAX_KEYS_DEF && $urandom_range(0, 1) == 1) slot = 6'($urandom_range(m, 63));
          else if (m == 0) slot = 6'($urandom_range(0, 63));
          else slot = 6'($urandom_range(0, m - 1));
          push_word(key_word(slot, any_word(), rand_vec()), 1'b0, '0);
        end else begin
          if (m == 0 || r < 25) begin
            q = any_word();
          end else if (r < 45) begin
            q = trk_time[$urandom_range(0, m - 1)] + 32'($urandom_range(0, 2)) - 32'd1;
          end else if (r < 52) begin
            q = r[0] ? SAT_MAX : SAT_MIN;
          end else begin
            lo = trk_time[0];
            span = longint'(trk_time[m-1]) - lo + 1;
            if (span > 1) q = 32'(lo + longint'({$urandom(), $urandom()} % span));
            else q = any_word();
          end
          push_word(query_word(q), 1'b0, '0);
        end
      end
      phase++;
    end

    drain_block();
    if (mismatches == 0) begin
      $display("tb_keyframe_vec3_interpolation_unit OK");
    end else begin
      $display("tb_keyframe_vec3_interpolation_unit NOT OK");
    end
    $finish;
  end

endmodule
